// ----- design/tbeq_pkg.sv -----
package tbeq_pkg;

  localparam int unsigned SMP_W     = 16;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned BAND_W    = 2;
  localparam int unsigned TAPIDX_W  = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned NUM_BANDS = 3;

  // Q4.12 gain, reset value means unity.
  localparam logic [GAIN_W-1:0] GAIN_ONE  = 16'd4096;
  localparam int unsigned       FRAC_BITS = 12;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  localparam logic [BAND_W-1:0] BAND_LOW  = 2'd0;
  localparam logic [BAND_W-1:0] BAND_MID  = 2'd1;
  localparam logic [BAND_W-1:0] BAND_HIGH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MID    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TREBLE = 2'd2;

  // Magnitude after the Q4.12 shift, clamped so that the quotient by three
  // still saturates correctly on both signs (three times 32769).
  localparam int unsigned       MAG_W       = 17;
  localparam logic [MAG_W-1:0]  MAG_CLAMP   = 17'd98307;
  // floor(m / 3) = (m * ceil(2^19 / 3)) >> 19, exact for any 17-bit m.
  localparam int unsigned       RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP3     = 18'd174763;
  localparam int unsigned       RECIP_SHIFT = 19;
  localparam int unsigned       QUO_W       = 16;

  localparam logic [SMP_W-1:0] SMP_POS_MAX = 16'h7fff;
  localparam logic [SMP_W-1:0] SMP_NEG_MAX = 16'h8000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_FLUSH,
    S_GAIN,
    S_SUM,
    S_MAG,
    S_DIV,
    S_OUT
  } ctl_state_e;

  typedef struct packed {
    logic smp_we;
    logic coef_we;
    logic acc_clr;
    logic issue;
    logic gain_en;
    logic sum_en;
    logic mag_en;
    logic div_en;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- design/tbeq_ctrl.sv -----
module tbeq_ctrl
  import tbeq_pkg::*;
#(
  parameter int unsigned TAPS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_mode_i,
  output logic                    in_ready_o,
  input  dp_sts_t                 sts_i,
  output dp_cmd_t                 cmd_o,
  output logic [$clog2(TAPS)-1:0] tap_k_o
);

  localparam int unsigned PTR_W = $clog2(TAPS);
  localparam logic [PTR_W-1:0] LAST_TAP = PTR_W'(TAPS - 1);

  ctl_state_e       state_q, state_d;
  logic [PTR_W-1:0] k_q, k_d;
  logic             in_xfer;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign tap_k_o    = k_q;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    case (state_q)
      S_IDLE: begin
        k_d = '0;
        if (in_xfer && (in_mode_i == MODE_SAMPLE)) begin
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        if (k_q == LAST_TAP) begin
          k_d     = '0;
          state_d = S_FLUSH;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_FLUSH: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_GAIN;
        end
      end
      S_GAIN: state_d = S_SUM;
      S_SUM:  state_d = S_MAG;
      S_MAG:  state_d = S_DIV;
      S_DIV:  state_d = S_OUT;
      S_OUT: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_mode_i == MODE_COEF) begin
            cmd_o.coef_we = 1'b1;
          end else begin
            cmd_o.smp_we  = 1'b1;
            cmd_o.acc_clr = 1'b1;
          end
        end
      end
      S_MAC:   cmd_o.issue    = 1'b1;
      S_FLUSH: cmd_o          = '0;
      S_GAIN:  cmd_o.gain_en  = 1'b1;
      S_SUM:   cmd_o.sum_en   = 1'b1;
      S_MAG:   cmd_o.mag_en   = 1'b1;
      S_DIV:   cmd_o.div_en   = 1'b1;
      S_OUT:   cmd_o.load_out = sts_i.out_free;
      default: cmd_o          = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // A sample transfer always starts a tap sweep from the newest sample.
  a_sample_starts_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (in_mode_i == MODE_SAMPLE)) |=> (state_q == S_MAC && k_q == '0))
    else $error("sample transfer did not start a tap sweep at tap zero");

  a_sweep_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC && k_q == LAST_TAP) |=> (state_q == S_FLUSH))
    else $error("tap sweep did not end after the last tap");

  a_result_then_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && sts_i.out_free) |=> (state_q == S_IDLE && in_ready_o))
    else $error("block not ready after handing over a result");

endmodule

// ----- design/tbeq_datapath.sv -----
module tbeq_datapath
  import tbeq_pkg::*;
#(
  parameter int unsigned TAPS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  output dp_sts_t                 sts_o,
  input  logic [$clog2(TAPS)-1:0] tap_k_i,
  input  logic [SMP_W-1:0]        sample_i,
  input  logic [BAND_W-1:0]       band_i,
  input  logic [TAPIDX_W-1:0]     tap_idx_i,
  input  logic [SMP_W-1:0]        coef_i,
  input  logic                    cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [GAIN_W-1:0]       cfg_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SMP_W-1:0]        out_sample_o
);

  localparam int unsigned PTR_W  = $clog2(TAPS);
  localparam int unsigned CNT_W  = $clog2(TAPS + 1);
  localparam int unsigned PROD_W = 2 * SMP_W;
  localparam int unsigned ACC_W  = PROD_W + $clog2(TAPS);
  localparam int unsigned GP_W   = ACC_W + GAIN_W + 1;
  localparam int unsigned TOT_W  = GP_W + 2;
  localparam int unsigned DIVP_W = MAG_W + RECIP_W;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(TAPS - 1);
  localparam logic [CNT_W-1:0] TAPS_CNT = CNT_W'(TAPS);

  // Configuration registers.
  logic [GAIN_W-1:0] gain_q [NUM_BANDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q[0] <= GAIN_ONE;
      gain_q[1] <= GAIN_ONE;
      gain_q[2] <= GAIN_ONE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BASS:   gain_q[0] <= cfg_data_i;
        CFG_MID:    gain_q[1] <= cfg_data_i;
        CFG_TREBLE: gain_q[2] <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Delay line as a circular buffer. wp_q points at the newest sample and
  // fill_q counts samples seen so far, up to TAPS; older taps read as zero.
  logic [PTR_W-1:0] wp_q, wp_n, rd_addr;
  logic [CNT_W-1:0] fill_q;
  logic [SMP_W-1:0] dly_mem [TAPS];
  logic [SMP_W-1:0] dly_rd_q;
  logic             tap_ok_q;
  logic             rd_vld_q;

  assign wp_n = (wp_q == LAST_PTR) ? '0 : wp_q + 1'b1;

  always_comb begin
    if (wp_q >= tap_k_i) begin
      rd_addr = wp_q - tap_k_i;
    end else begin
      rd_addr = PTR_W'(CNT_W'(wp_q) + TAPS_CNT - CNT_W'(tap_k_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      fill_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.smp_we) begin
        wp_q <= wp_n;
        if (fill_q != TAPS_CNT) begin
          fill_q <= fill_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.smp_we) begin
      dly_mem[wp_n] <= sample_i;
    end
    if (cmd_i.issue) begin
      dly_rd_q <= dly_mem[rd_addr];
      tap_ok_q <= (CNT_W'(tap_k_i) < fill_q);
    end
  end

  // Coefficient memories, one per band, all read at the same tap.
  logic                    tap_in_range;
  logic [PTR_W-1:0]        coef_wr_addr;
  logic signed [SMP_W-1:0] coef_rd_q [NUM_BANDS];

  assign tap_in_range = (32'(tap_idx_i) < TAPS);
  assign coef_wr_addr = PTR_W'(tap_idx_i);

  for (genvar b = 0; b < NUM_BANDS; b++) begin : g_band
    logic [SMP_W-1:0] coef_mem [TAPS];

    always_ff @(posedge clk_i) begin
      if (cmd_i.coef_we && tap_in_range && (band_i == BAND_W'(b))) begin
        coef_mem[coef_wr_addr] <= coef_i;
      end
      if (cmd_i.issue) begin
        coef_rd_q[b] <= $signed(coef_mem[tap_k_i]);
      end
    end
  end

  // Multiply-accumulate, one tap of all three bands per cycle.
  logic signed [SMP_W-1:0]  dly_s;
  logic signed [PROD_W-1:0] prod_q [NUM_BANDS];
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q [NUM_BANDS];

  assign dly_s = tap_ok_q ? $signed(dly_rd_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= rd_vld_q;
    end
  end

  for (genvar b = 0; b < NUM_BANDS; b++) begin : g_mac
    always_ff @(posedge clk_i) begin
      if (rd_vld_q) begin
        prod_q[b] <= PROD_W'(dly_s) * PROD_W'(coef_rd_q[b]);
      end
      if (cmd_i.acc_clr) begin
        acc_q[b] <= '0;
      end else if (prod_vld_q) begin
        acc_q[b] <= acc_q[b] + ACC_W'(prod_q[b]);
      end
    end
  end

  // Gain weighting, sum, then division by three times unity gain.
  logic signed [GP_W-1:0]  gp_q [NUM_BANDS];
  logic signed [TOT_W-1:0] tot_q;
  logic [TOT_W-1:0]        tot_abs;
  logic [TOT_W-1:0]        tot_shr;
  logic [MAG_W-1:0]        mag_d, mag_q;
  logic                    neg_q;
  logic [DIVP_W-1:0]       divp;
  logic [QUO_W-1:0]        quo_q;
  logic [SMP_W-1:0]        out_d, out_q;
  logic                    out_vld_q;

  for (genvar b = 0; b < NUM_BANDS; b++) begin : g_gain
    logic signed [GAIN_W:0] gain_s;

    assign gain_s = $signed({1'b0, gain_q[b]});

    always_ff @(posedge clk_i) begin
      if (cmd_i.gain_en) begin
        gp_q[b] <= GP_W'(acc_q[b]) * GP_W'(gain_s);
      end
    end
  end

  assign tot_abs = tot_q[TOT_W-1] ? $unsigned(-tot_q) : $unsigned(tot_q);
  assign tot_shr = tot_abs >> FRAC_BITS;
  assign mag_d   = (tot_shr > TOT_W'(MAG_CLAMP)) ? MAG_CLAMP : MAG_W'(tot_shr);
  assign divp    = DIVP_W'(mag_q) * DIVP_W'(RECIP3);

  always_comb begin
    if (neg_q) begin
      out_d = (quo_q >= SMP_NEG_MAX) ? SMP_NEG_MAX : SMP_W'(-quo_q);
    end else begin
      out_d = (quo_q > SMP_POS_MAX) ? SMP_POS_MAX : SMP_W'(quo_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      tot_q <= TOT_W'(gp_q[0]) + TOT_W'(gp_q[1]) + TOT_W'(gp_q[2]);
    end
    if (cmd_i.mag_en) begin
      mag_q <= mag_d;
      neg_q <= tot_q[TOT_W-1];
    end
    if (cmd_i.div_en) begin
      quo_q <= divp[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_sample_o    = out_q;
  assign sts_o.pipe_busy = rd_vld_q || prod_vld_q;
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= TAPS_CNT)
    else $error("delay line fill count beyond the filter length");

  a_gain_after_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gain_en |-> !(rd_vld_q || prod_vld_q || cmd_i.issue))
    else $error("gain stage started while taps still in flight");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_vld_q || out_ready_i))
    else $error("result register loaded over an untaken result");

endmodule

// ----- design/three_band_fir_equalizer_top.sv -----
// Three-band FIR graphic equalizer.
//
// Input stream (s_axis): tuser selects the item kind. With tuser low the item
// is an audio sample: it enters the shared delay line and yields one output
// sample on m_axis. With tuser high it writes one coefficient of one band and
// yields nothing; writes to band 3 or to tap index TAPS or above are dropped.
// All 3*TAPS coefficients must be loaded before the first audio sample.
// The always-ready cfg channel writes the three Q4.12 band gains (index 0
// bass, 1 mid, 2 treble), by the user only while the block is idle (unchecked).
//
// An audio sample keeps the block busy after its transfer: a tap sweep of the
// shared three-lane multiply-accumulate, a pipeline drain, then the gain, sum,
// magnitude, divide and saturation steps. The result shows on m_axis in the
// cycle the block is ready again, so the block takes no new audio sample
// before the last result is loaded into the output register.
// A coefficient write leaves the block idle and ready.
// The result sits in an output register; if the receiver stalls, the block
// takes and processes the next item and waits only before loading a new result.
// Reset makes the delay line read as zeros and sets all gains to unity (4096).
module three_band_fir_equalizer_top
  import tbeq_pkg::*;
#(
  parameter int unsigned TAPS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [15:0] sample, [17:16] band, [23:18] tap_index, [39:24] coefficient
  input  logic [39:0]          s_axis_tdata,
  // [0] mode
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [15:0] out_sample
  output logic [15:0]          m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GAIN_W-1:0]    cfg_data_i
);

  dp_cmd_t                 cmd;
  dp_sts_t                 sts;
  logic [$clog2(TAPS)-1:0] tap_k;

  assign cfg_ready_o = 1'b1;

  tbeq_ctrl #(
    .TAPS (TAPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .tap_k_o    (tap_k)
  );

  tbeq_datapath #(
    .TAPS (TAPS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .tap_k_i      (tap_k),
    .sample_i     (s_axis_tdata[15:0]),
    .band_i       (s_axis_tdata[17:16]),
    .tap_idx_i    (s_axis_tdata[23:18]),
    .coef_i       (s_axis_tdata[39:24]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (m_axis_tdata)
  );

endmodule
